@@ rtl/tiq_pkg.sv @@
`default_nettype none
package tiq_pkg;

  // Edge vectors and first products
  localparam int EW      = 21;  // edge component, signed
  localparam int PW      = 42;  // signed product of a pair of edge components
  localparam int SQ_W    = 41;  // square of an edge component
  localparam int LW      = 42;  // squared edge length
  localparam int NW      = 43;  // cross product component, signed
  localparam int MW      = 42;  // cross product component magnitude
  localparam int HALF_W  = 21;  // split point for squaring a magnitude

  // Triple product
  localparam int DSPLIT  = 22;
  localparam int DPH_W   = EW + NW - DSPLIT;
  localparam int DPL_W   = EW + DSPLIT + 1;
  localparam int DETW    = 64;
  localparam int DMW     = 63;

  // Face norms and roots
  localparam int SQW       = 84;  // squared cross product length
  localparam int NORM_FRAC = 20;
  localparam int ROOT_W    = 62;
  localparam int SW        = 64;  // sum of four face norms
  localparam int LFW       = 41;  // scaled longest edge

  // sqrt(24) in Q.30
  localparam int K_FRAC = 30;
  localparam int KW     = 33;
  localparam logic [KW-1:0] K_SQRT24 = 33'd5260239168;

  // Final products
  localparam int D_SPLIT  = 32;
  localparam int S_SPLIT  = 32;
  localparam int LF_SPLIT = 21;
  localparam int NPW      = DMW + KW;
  localparam int DENW     = SW + LFW;

  // Result
  localparam int Q_W = 18;
  localparam int QB  = Q_W - 1;

  localparam int NE = 6;
  localparam int NF = 4;

  // Edge k runs from vertex EDGE_I[k] to vertex EDGE_J[k]
  localparam int EDGE_I [NE] = '{0, 0, 0, 1, 1, 2};
  localparam int EDGE_J [NE] = '{1, 2, 3, 2, 3, 3};
  // Face f normal is edge FACE_A[f] cross edge FACE_B[f]
  localparam int FACE_A [NF] = '{0, 0, 1, 3};
  localparam int FACE_B [NF] = '{1, 2, 2, 4};
  // Cyclic component order for cross products
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

endpackage
`default_nettype wire

@@ rtl/tiq_isqrt.sv @@
`default_nettype none
module tiq_isqrt #(
  parameter int ROOT_W = 62
) (
  input  wire logic                  clk,
  input  wire logic [2*ROOT_W-1:0]   rad,
  output logic      [ROOT_W-1:0]     root
);

  logic [ROOT_W+1:0]   rem_r  [ROOT_W-1];
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [2*ROOT_W-1:0] x_r    [ROOT_W-1];

  // One root bit per stage, restoring digit recurrence
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stg
    logic [ROOT_W+1:0]   rem_in;
    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] x_in;
    logic                ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = rad;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign x_in    = x_r[i-1];
    end

    assign rem_sh = {rem_in[ROOT_W-1:0], x_in[2*ROOT_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      root_r[i] <= {root_in[ROOT_W-2:0], ge};
    end

    if (i < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[i] <= ge ? (rem_sh - trial) : rem_sh;
        x_r[i]   <= x_in << 2;
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule
`default_nettype wire

@@ rtl/tetrahedron_insphere_edge_quality_core.sv @@
// Throughput: one tetrahedron per cycle; busy is tied low, the pipeline never stalls.
// Most depth is in the 62-stage pipelined square root units and the 18-stage divider.
// The receiver cannot stall: each result is on out_* for exactly one cycle.
// Synchronous active-low reset clears every valid bit; beats in flight are dropped.
`default_nettype none
module tetrahedron_insphere_edge_quality_core #(
  parameter int COORD_BITS        = 20,
  parameter int QUALITY_FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] in_p0_x,
  input  wire logic signed [COORD_BITS-1:0] in_p0_y,
  input  wire logic signed [COORD_BITS-1:0] in_p0_z,
  input  wire logic signed [COORD_BITS-1:0] in_p1_x,
  input  wire logic signed [COORD_BITS-1:0] in_p1_y,
  input  wire logic signed [COORD_BITS-1:0] in_p1_z,
  input  wire logic signed [COORD_BITS-1:0] in_p2_x,
  input  wire logic signed [COORD_BITS-1:0] in_p2_y,
  input  wire logic signed [COORD_BITS-1:0] in_p2_z,
  input  wire logic signed [COORD_BITS-1:0] in_p3_x,
  input  wire logic signed [COORD_BITS-1:0] in_p3_y,
  input  wire logic signed [COORD_BITS-1:0] in_p3_z,
  output logic                              out_valid,
  output logic signed [tiq_pkg::Q_W-1:0]    out_quality,
  output logic                              out_degenerate
);

  // Local copies of package widths used in size casts
  localparam int EW       = tiq_pkg::EW;
  localparam int PW       = tiq_pkg::PW;
  localparam int SQ_W     = tiq_pkg::SQ_W;
  localparam int LW       = tiq_pkg::LW;
  localparam int NW       = tiq_pkg::NW;
  localparam int MW       = tiq_pkg::MW;
  localparam int HALF_W   = tiq_pkg::HALF_W;
  localparam int DSPLIT   = tiq_pkg::DSPLIT;
  localparam int DETW     = tiq_pkg::DETW;
  localparam int DMW      = tiq_pkg::DMW;
  localparam int SQW      = tiq_pkg::SQW;
  localparam int ROOT_W   = tiq_pkg::ROOT_W;
  localparam int SW       = tiq_pkg::SW;
  localparam int LFW      = tiq_pkg::LFW;
  localparam int NPW      = tiq_pkg::NPW;
  localparam int DENW     = tiq_pkg::DENW;
  localparam int D_SPLIT  = tiq_pkg::D_SPLIT;
  localparam int S_SPLIT  = tiq_pkg::S_SPLIT;
  localparam int LF_SPLIT = tiq_pkg::LF_SPLIT;
  localparam int Q_W      = tiq_pkg::Q_W;
  localparam int QB       = tiq_pkg::QB;
  localparam int NE       = tiq_pkg::NE;
  localparam int NF       = tiq_pkg::NF;

  // Edge extraction: wide coordinates are cut to the fixed edge width
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int PRE_SHIFT = (COORD_BITS > EW - 1) ? (COORD_BITS - (EW - 1)) : 0;

  // Radicand padding gives the Q.20 scale on every root
  localparam int RAD_PAD = 2 * tiq_pkg::NORM_FRAC;
  localparam int LF_TOP  = 2 * ROOT_W - LW - RAD_PAD;

  // Numerator scale and divider width
  localparam int NUM_SH = 2 * tiq_pkg::NORM_FRAC - tiq_pkg::K_FRAC + QUALITY_FRAC_BITS;
  localparam int NUM_W  = NPW + NUM_SH;
  localparam int CMP_W  = (NUM_W > DENW + QB) ? NUM_W : (DENW + QB);

  // Product widths for the last multiply stage
  localparam int NPLO_W = D_SPLIT + tiq_pkg::KW;
  localparam int NPHI_W = (DMW - D_SPLIT) + tiq_pkg::KW;
  localparam int LFH_W  = LFW - LF_SPLIT;
  localparam int SH_W   = SW - S_SPLIT;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};

  // The core never holds off a start beat
  assign busy = 1'b0;

  logic in_fire;
  assign in_fire = start & ~busy;

  logic signed [COORD_BITS-1:0] pt [4][3];

  assign pt[0][0] = in_p0_x;
  assign pt[0][1] = in_p0_y;
  assign pt[0][2] = in_p0_z;
  assign pt[1][0] = in_p1_x;
  assign pt[1][1] = in_p1_y;
  assign pt[1][2] = in_p1_z;
  assign pt[2][0] = in_p2_x;
  assign pt[2][1] = in_p2_y;
  assign pt[2][2] = in_p2_z;
  assign pt[3][0] = in_p3_x;
  assign pt[3][1] = in_p3_y;
  assign pt[3][2] = in_p3_z;

  //--------------------------------------------------------------------------
  // Stage 1: an edge vector per vertex pair. Magnitude is shifted down, so rounding is
  // toward zero, then the sign is restored.
  //--------------------------------------------------------------------------
  logic signed [EW-1:0] e1_nxt [NE][3];
  logic signed [EW-1:0] e1_r   [NE][3];
  logic                 v1_r;

  always_comb begin
    logic signed [DIFF_W-1:0] dif;
    logic        [DIFF_W-1:0] mag;
    logic        [DIFF_W-1:0] shm;
    logic        [EW-1:0]     em;
    for (int k = 0; k < NE; k++) begin
      for (int c = 0; c < 3; c++) begin
        dif = DIFF_W'(pt[tiq_pkg::EDGE_J[k]][c]) - DIFF_W'(pt[tiq_pkg::EDGE_I[k]][c]);
        mag = dif[DIFF_W-1] ? -dif : dif;
        shm = mag >> PRE_SHIFT;
        em  = EW'(shm);
        e1_nxt[k][c] = dif[DIFF_W-1] ? -$signed(em) : $signed(em);
      end
    end
  end

  always_ff @(posedge clk) begin
    e1_r <= e1_nxt;
  end

  //--------------------------------------------------------------------------
  // Stage 2: cross product partial products and squared edge components
  //--------------------------------------------------------------------------
  logic signed [PW-1:0]   xa2_r  [NF][3];
  logic signed [PW-1:0]   xb2_r  [NF][3];
  logic        [SQ_W-1:0] sq2_nxt [NE][3];
  logic        [SQ_W-1:0] sq2_r  [NE][3];
  logic signed [EW-1:0]   e2_r   [3];
  logic                   v2_r;

  always_comb begin
    logic signed [PW-1:0] sp;
    for (int k = 0; k < NE; k++) begin
      for (int c = 0; c < 3; c++) begin
        sp = e1_r[k][c] * e1_r[k][c];
        sq2_nxt[k][c] = sp[SQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int f = 0; f < NF; f++) begin
      for (int c = 0; c < 3; c++) begin
        xa2_r[f][c] <= e1_r[tiq_pkg::FACE_A[f]][tiq_pkg::NXT1[c]]
                     * e1_r[tiq_pkg::FACE_B[f]][tiq_pkg::NXT2[c]];
        xb2_r[f][c] <= e1_r[tiq_pkg::FACE_A[f]][tiq_pkg::NXT2[c]]
                     * e1_r[tiq_pkg::FACE_B[f]][tiq_pkg::NXT1[c]];
      end
    end
    sq2_r <= sq2_nxt;
    e2_r  <= e1_r[0];
  end

  //--------------------------------------------------------------------------
  // Stage 3: face normals and squared edge lengths
  //--------------------------------------------------------------------------
  logic signed [NW-1:0] n3_r   [NF][3];
  logic        [LW-1:0] len3_r [NE];
  logic signed [EW-1:0] e3_r   [3];
  logic                 v3_r;

  always_ff @(posedge clk) begin
    for (int f = 0; f < NF; f++) begin
      for (int c = 0; c < 3; c++) begin
        n3_r[f][c] <= NW'(xa2_r[f][c]) - NW'(xb2_r[f][c]);
      end
    end
    for (int k = 0; k < NE; k++) begin
      len3_r[k] <= LW'(sq2_r[k][0]) + LW'(sq2_r[k][1]) + LW'(sq2_r[k][2]);
    end
    e3_r <= e2_r;
  end

  //--------------------------------------------------------------------------
  // Stage 4: normal magnitudes, triple product partials, first max level.
  // The third face normal is edge 1 cross edge 2, so edge 0 dotted with it
  // is six times the signed volume.
  //--------------------------------------------------------------------------
  logic        [MW-1:0]             mag4_nxt [NF][3];
  logic        [MW-1:0]             mag4_r   [NF][3];
  logic signed [tiq_pkg::DPH_W-1:0] dph4_r   [3];
  logic signed [tiq_pkg::DPL_W-1:0] dpl4_r   [3];
  logic        [LW-1:0]             lm4_r    [3];
  logic                             v4_r;

  always_comb begin
    logic signed [NW-1:0] nneg;
    for (int f = 0; f < NF; f++) begin
      for (int c = 0; c < 3; c++) begin
        nneg = -n3_r[f][c];
        mag4_nxt[f][c] = n3_r[f][c][NW-1] ? MW'(nneg) : MW'(n3_r[f][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    mag4_r <= mag4_nxt;
    for (int c = 0; c < 3; c++) begin
      dph4_r[c] <= e3_r[c] * $signed(n3_r[2][c][NW-1:DSPLIT]);
      dpl4_r[c] <= e3_r[c] * $signed({1'b0, n3_r[2][c][DSPLIT-1:0]});
    end
    for (int j = 0; j < 3; j++) begin
      lm4_r[j] <= (len3_r[2*j] >= len3_r[2*j+1]) ? len3_r[2*j] : len3_r[2*j+1];
    end
  end

  //--------------------------------------------------------------------------
  // Stage 5: square each magnitude as three half-width products,
  // finish the triple product and the longest edge
  //--------------------------------------------------------------------------
  logic        [2*HALF_W-1:0] hh5_r [NF][3];
  logic        [2*HALF_W-1:0] hl5_r [NF][3];
  logic        [2*HALF_W-1:0] ll5_r [NF][3];
  logic signed [DETW-1:0]     det5_nxt;
  logic signed [DETW-1:0]     det5_r;
  logic        [LW-1:0]       lm5_nxt;
  logic        [LW-1:0]       lm5_r;
  logic                       v5_r;

  always_comb begin
    det5_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      det5_nxt = det5_nxt + (DETW'(dph4_r[c]) <<< DSPLIT) + DETW'(dpl4_r[c]);
    end
    lm5_nxt = (lm4_r[0] >= lm4_r[1]) ? lm4_r[0] : lm4_r[1];
    lm5_nxt = (lm5_nxt >= lm4_r[2]) ? lm5_nxt : lm4_r[2];
  end

  always_ff @(posedge clk) begin
    for (int f = 0; f < NF; f++) begin
      for (int c = 0; c < 3; c++) begin
        hh5_r[f][c] <= mag4_r[f][c][MW-1:HALF_W] * mag4_r[f][c][MW-1:HALF_W];
        hl5_r[f][c] <= mag4_r[f][c][MW-1:HALF_W] * mag4_r[f][c][HALF_W-1:0];
        ll5_r[f][c] <= mag4_r[f][c][HALF_W-1:0] * mag4_r[f][c][HALF_W-1:0];
      end
    end
    det5_r <= det5_nxt;
    lm5_r  <= lm5_nxt;
  end

  //--------------------------------------------------------------------------
  // Stage 6: recombine component squares, take the volume magnitude
  //--------------------------------------------------------------------------
  logic [SQW-1:0] csq6_r [NF][3];
  logic [DMW-1:0] dm6_nxt;
  logic [DMW-1:0] dm6_r;
  logic [LW-1:0]  lm6_r;
  logic           v6_r;

  always_comb begin
    logic signed [DETW-1:0] dneg;
    dneg    = -det5_r;
    dm6_nxt = det5_r[DETW-1] ? DMW'(dneg) : DMW'(det5_r);
  end

  always_ff @(posedge clk) begin
    for (int f = 0; f < NF; f++) begin
      for (int c = 0; c < 3; c++) begin
        csq6_r[f][c] <= (SQW'(hh5_r[f][c]) << (2*HALF_W))
                      + (SQW'(hl5_r[f][c]) << (HALF_W + 1))
                      + SQW'(ll5_r[f][c]);
      end
    end
    dm6_r <= dm6_nxt;
    lm6_r <= lm5_r;
  end

  //--------------------------------------------------------------------------
  // Stage 7: squared face normal lengths
  //--------------------------------------------------------------------------
  logic [SQW-1:0] fsq7_r [NF];
  logic [DMW-1:0] dm7_r;
  logic [LW-1:0]  lm7_r;
  logic           v7_r;

  always_ff @(posedge clk) begin
    for (int f = 0; f < NF; f++) begin
      fsq7_r[f] <= csq6_r[f][0] + csq6_r[f][1] + csq6_r[f][2];
    end
    dm7_r <= dm6_r;
    lm7_r <= lm6_r;
  end

  //--------------------------------------------------------------------------
  // Square roots: four face norms and the longest edge, all at Q.20.
  // Sideband (volume, zero-edge flag, valid) rides a matching delay line.
  //--------------------------------------------------------------------------
  logic [2*ROOT_W-1:0] rad  [NF+1];
  logic [ROOT_W-1:0]   root [NF+1];

  for (genvar f = 0; f < NF; f++) begin : g_face_rad
    assign rad[f] = {fsq7_r[f], {RAD_PAD{1'b0}}};
  end
  assign rad[NF] = {{LF_TOP{1'b0}}, lm7_r, {RAD_PAD{1'b0}}};

  for (genvar u = 0; u < NF + 1; u++) begin : g_sqrt
    tiq_isqrt #(
      .ROOT_W (ROOT_W)
    ) u_isqrt (
      .clk  (clk),
      .rad  (rad[u]),
      .root (root[u])
    );
  end

  logic [DMW-1:0]    dm_dl_r [ROOT_W];
  logic              lz_dl_r [ROOT_W];
  logic [ROOT_W-1:0] vq_r;

  always_ff @(posedge clk) begin
    dm_dl_r[0] <= dm7_r;
    lz_dl_r[0] <= (lm7_r == '0);
    for (int i = 1; i < ROOT_W; i++) begin
      dm_dl_r[i] <= dm_dl_r[i-1];
      lz_dl_r[i] <= lz_dl_r[i-1];
    end
  end

  //--------------------------------------------------------------------------
  // Stage A: face norm sum and degenerate flag
  //--------------------------------------------------------------------------
  logic [SW-1:0]  sa_nxt;
  logic [SW-1:0]  sa_r;
  logic [LFW-1:0] lfa_r;
  logic [DMW-1:0] dma_r;
  logic           dega_r;
  logic           va_r;

  always_comb begin
    sa_nxt = SW'(root[0]) + SW'(root[1]) + SW'(root[2]) + SW'(root[3]);
  end

  always_ff @(posedge clk) begin
    sa_r   <= sa_nxt;
    lfa_r  <= root[NF][LFW-1:0];
    dma_r  <= dm_dl_r[ROOT_W-1];
    dega_r <= lz_dl_r[ROOT_W-1] | (sa_nxt == '0);
  end

  //--------------------------------------------------------------------------
  // Stage B: split products for numerator (|6V| * K) and denominator (S * Lf)
  //--------------------------------------------------------------------------
  logic [NPLO_W-1:0]            nplo_r;
  logic [NPHI_W-1:0]            nphi_r;
  logic [S_SPLIT+LF_SPLIT-1:0]  pll_r;
  logic [S_SPLIT+LFH_W-1:0]     plh_r;
  logic [SH_W+LF_SPLIT-1:0]     phl_r;
  logic [SH_W+LFH_W-1:0]        phh_r;
  logic                         degb_r;
  logic                         vb_r;

  always_ff @(posedge clk) begin
    nplo_r <= dma_r[D_SPLIT-1:0] * tiq_pkg::K_SQRT24;
    nphi_r <= dma_r[DMW-1:D_SPLIT] * tiq_pkg::K_SQRT24;
    pll_r  <= sa_r[S_SPLIT-1:0] * lfa_r[LF_SPLIT-1:0];
    plh_r  <= sa_r[S_SPLIT-1:0] * lfa_r[LFW-1:LF_SPLIT];
    phl_r  <= sa_r[SW-1:S_SPLIT] * lfa_r[LF_SPLIT-1:0];
    phh_r  <= sa_r[SW-1:S_SPLIT] * lfa_r[LFW-1:LF_SPLIT];
    degb_r <= dega_r;
  end

  //--------------------------------------------------------------------------
  // Stage C: sum the partial products
  //--------------------------------------------------------------------------
  logic [NPW-1:0]  numc_r;
  logic [DENW-1:0] denc_r;
  logic            degc_r;
  logic            vc_r;

  always_ff @(posedge clk) begin
    numc_r <= NPW'(nplo_r) + (NPW'(nphi_r) << D_SPLIT);
    denc_r <= DENW'(pll_r)
            + (DENW'(plh_r) << LF_SPLIT)
            + (DENW'(phl_r) << S_SPLIT)
            + (DENW'(phh_r) << (S_SPLIT + LF_SPLIT));
    degc_r <= degb_r;
  end

  //--------------------------------------------------------------------------
  // Divider: saturation check, then one quotient bit per stage, MSB first
  //--------------------------------------------------------------------------
  logic [CMP_W-1:0] drem_r [QB];
  logic [DENW-1:0]  dden_r [QB];
  logic [QB-1:0]    dq_r   [QB+1];
  logic             dsat_r [QB+1];
  logic             ddeg_r [QB+1];
  logic [QB:0]      dv_r;
  logic [CMP_W-1:0] drem0;

  assign drem0 = CMP_W'(numc_r) << NUM_SH;

  always_ff @(posedge clk) begin
    drem_r[0] <= drem0;
    dden_r[0] <= denc_r;
    dq_r[0]   <= '0;
    dsat_r[0] <= (drem0 >= (CMP_W'(denc_r) << QB));
    ddeg_r[0] <= degc_r;
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int BIT = QB - j;
    logic [CMP_W-1:0] trial;
    logic             ge;

    assign trial = CMP_W'(dden_r[j-1]) << BIT;
    assign ge    = (drem_r[j-1] >= trial);

    always_ff @(posedge clk) begin
      dq_r[j]   <= dq_r[j-1] | (QB'(ge) << BIT);
      dsat_r[j] <= dsat_r[j-1];
      ddeg_r[j] <= ddeg_r[j-1];
    end

    if (j < QB) begin : g_rem
      always_ff @(posedge clk) begin
        drem_r[j] <= ge ? (drem_r[j-1] - trial) : drem_r[j-1];
        dden_r[j] <= dden_r[j-1];
      end
    end
  end

  //--------------------------------------------------------------------------
  // Output register: degenerate forces zero, overrange clamps
  //--------------------------------------------------------------------------
  logic [Q_W-1:0] q_nxt;
  logic [Q_W-1:0] out_quality_r;
  logic           out_degenerate_r;
  logic           out_valid_r;

  always_comb begin
    if (ddeg_r[QB]) begin
      q_nxt = '0;
    end else if (dsat_r[QB]) begin
      q_nxt = Q_MAX;
    end else begin
      q_nxt = {1'b0, dq_r[QB]};
    end
  end

  always_ff @(posedge clk) begin
    out_quality_r    <= q_nxt;
    out_degenerate_r <= ddeg_r[QB];
  end

  // Valid bits: the only state that reset touches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      vq_r        <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_fire;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      vq_r        <= {vq_r[ROOT_W-2:0], v7_r};
      va_r        <= vq_r[ROOT_W-1];
      vb_r        <= va_r;
      vc_r        <= vb_r;
      dv_r        <= {dv_r[QB-1:0], vc_r};
      out_valid_r <= dv_r[QB];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quality    = $signed(out_quality_r);
  assign out_degenerate = out_degenerate_r;

endmodule
`default_nettype wire
